FILE: sv/lctp_pkg.sv
// lctp_pkg: shared constants, register codes and coefficient tables of the
// lab color transfer pixel pipeline. no dependencies.
`timescale 1ns / 1ps

package lctp_pkg;

  // configuration register codes
  typedef enum logic [2:0] {
    CFG_GAIN_L       = 3'd0,
    CFG_GAIN_ALPHA   = 3'd1,
    CFG_GAIN_BETA    = 3'd2,
    CFG_OFFSET_L     = 3'd3,
    CFG_OFFSET_ALPHA = 3'd4,
    CFG_OFFSET_BETA  = 3'd5
  } cfg_reg_t;

  localparam logic signed [15:0] GAIN_RESET   = 16'sd4096;
  localparam logic signed [15:0] OFFSET_RESET = 16'sd0;

  localparam int LOG_STEPS = 24;
  localparam int POW_STEPS = 24;

  localparam logic signed [29:0] LOG2_255_Q24 = 30'sd134122994;
  localparam logic signed [29:0] LOG_BIAS_Q24 = 30'sd268435456;
  localparam logic signed [30:0] LOG10_2_Q30  = 31'sd323228497;
  localparam longint             LOG2_10_Q28  = 64'd891723283;
  localparam logic signed [16:0] LOG2_10_HI   = 17'(LOG2_10_Q28 >> 15);
  localparam logic signed [16:0] LOG2_10_LO   = 17'(LOG2_10_Q28 & 64'd32767);

  localparam logic signed [17:0] K3 = 18'sd37837;
  localparam logic signed [17:0] K6 = 18'sd26755;
  localparam logic signed [17:0] K2 = 18'sd46341;

  localparam logic signed [34:0] EXP_MIN = -35'sd536870912;
  localparam logic signed [34:0] EXP_MAX = 35'sd201326592;

  localparam logic [15:0] TO_LMS [3][3] = '{
    '{16'd24976, 16'd37899, 16'd2635},
    '{16'd12891, 16'd47474, 16'd5125},
    '{16'd1579,  16'd8441,  16'd55339}
  };

  localparam logic signed [19:0] TO_RGB [3][3] = '{
    '{20'sd292808, -20'sd235097, 20'sd7818},
    '{-20'sd79862, 20'sd156035,  -20'sd10643},
    '{20'sd3257,   -20'sd15984,  20'sd78938}
  };

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor(2^(2^-k) * 2^30) built as a chain of square roots
  function automatic logic [63:0] pow2_factor(input int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int j = 2; j <= k; j++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

endpackage

FILE: sv/lctp_log2.sv
// lctp_log2: pipelined log2 of a 24-bit unsigned value to q24, one squaring
// step per stage. depends on lctp_pkg.
`timescale 1ns / 1ps

module lctp_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [23:0] x,
  output logic        out_valid,
  output logic [28:0] log2
);

  localparam int N = lctp_pkg::LOG_STEPS;

  logic [30:0] m_q  [0:N];
  logic [23:0] fr_q [0:N];
  logic [4:0]  e_q  [0:N];
  logic        v_q  [0:N];

  logic [4:0]  e_n;
  logic [30:0] m_n;

  // leading one and normalize mantissa to [2^30, 2^31)
  always_comb begin
    e_n = '0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) e_n = 5'(i);
    end
    m_n = {7'b0, x} << (5'd30 - e_n);
  end

  always_ff @(posedge clk) begin
    if (rst) v_q[0] <= 1'b0;
    else if (en) v_q[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0]  <= m_n;
      fr_q[0] <= '0;
      e_q[0]  <= e_n;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m_q[g]) * 62'(m_q[g]);
    assign t  = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) v_q[g+1] <= 1'b0;
      else if (en) v_q[g+1] <= v_q[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[g+1]  <= t[31] ? t[31:1] : t[30:0];
        fr_q[g+1] <= {fr_q[g][22:0], t[31]};
        e_q[g+1]  <= e_q[g];
      end
    end
  end

  assign out_valid = v_q[N];
  assign log2      = {e_q[N], fr_q[N]};

endmodule

FILE: sv/lctp_pow2.sv
// lctp_pow2: pipelined 2^x for a clamped q24 exponent, one rom factor per
// stage, result q24 unsigned. depends on lctp_pkg.
`timescale 1ns / 1ps

module lctp_pow2 (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [30:0] v,
  output logic               out_valid,
  output logic [37:0]        lms
);

  localparam int N = lctp_pkg::POW_STEPS;

  logic signed [6:0] n_q [0:N];
  logic [23:0]       f_q [0:N];
  logic [31:0]       p_q [0:N];
  logic              v_q [0:N];

  always_ff @(posedge clk) begin
    if (rst) v_q[0] <= 1'b0;
    else if (en) v_q[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0] <= v[30:24];
      f_q[0] <= v[23:0];
      p_q[0] <= 32'd1 << 30;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_mul
    localparam logic [63:0] FACT = lctp_pkg::pow2_factor(k);
    logic [63:0] prod;
    assign prod = 64'(p_q[k-1]) * FACT + (64'd1 << 29);

    always_ff @(posedge clk) begin
      if (rst) v_q[k] <= 1'b0;
      else if (en) v_q[k] <= v_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k] <= n_q[k-1];
        f_q[k] <= f_q[k-1];
        p_q[k] <= f_q[k-1][N-k] ? prod[61:30] : p_q[k-1];
      end
    end
  end

  // final scale by 2^(n-6), rounding on right shifts
  logic signed [7:0] s;
  logic [5:0]        sh;
  logic [37:0]       lms_n;

  always_comb begin
    s  = 8'(n_q[N]) - 8'sd6;
    sh = 6'(-s);
    if (!s[7]) begin
      lms_n = 38'(p_q[N]) << s[2:0];
    end else begin
      lms_n = 38'((40'(p_q[N]) + (40'd1 << (sh - 6'd1))) >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_q[N];
  end

  always_ff @(posedge clk) begin
    if (en) lms <= lms_n;
  end

endmodule

FILE: sv/lab_color_transfer_pixel_top.sv
// lab_color_transfer_pixel_top: color transfer, one rgb pixel per clock unless
// stalled, in l-alpha-beta space. depends on lctp_pkg, lctp_log2, lctp_pow2.
`timescale 1ns / 1ps

// Takes one 3x8-bit rgb word per clock and returns one transferred rgb word per
// clock. Each channel is clamped to at least 1, mapped to lms, taken to log10
// space and to l-alpha-beta, where gain*x+offset is applied per channel (signed
// q3.12 registers, written through the cfg port; the user must write them only
// while idle, the block does not enforce it). The path back goes through 10^x
// and the inverse matrices; the result is rounded and saturated to 0..255.
// log2 takes 25 stages and 2^x 26, each one multiply per stage, plus 16 stages
// of matrix, affine and output arithmetic. The whole pipeline advances
// together; it halts only while the output word is stalled.
module lab_color_transfer_pixel_top #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out
);

  localparam int     SH  = 24 - FRAC_BITS;   // q24 to lab fraction shift
  localparam int     YW  = FRAC_BITS + 5;    // lab width after affine step
  localparam longint LIM = longint'(1) << (FRAC_BITS + 4);

  // pipeline advance: everything moves unless the output word is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration registers
  logic signed [15:0] gain [3];
  logic signed [15:0] offs [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        gain[i] <= lctp_pkg::GAIN_RESET;
        offs[i] <= lctp_pkg::OFFSET_RESET;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        lctp_pkg::CFG_GAIN_L:       gain[0] <= cfg_data;
        lctp_pkg::CFG_GAIN_ALPHA:   gain[1] <= cfg_data;
        lctp_pkg::CFG_GAIN_BETA:    gain[2] <= cfg_data;
        lctp_pkg::CFG_OFFSET_L:     offs[0] <= cfg_data;
        lctp_pkg::CFG_OFFSET_ALPHA: offs[1] <= cfg_data;
        lctp_pkg::CFG_OFFSET_BETA:  offs[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // offsets brought to the lab fraction
  logic signed [36:0] off_q [3];
  for (genvar c = 0; c < 3; c++) begin : g_off
    if (FRAC_BITS >= 12) begin : g_up
      assign off_q[c] = 37'(offs[c]) <<< (FRAC_BITS - 12);
    end else begin : g_dn
      assign off_q[c] = (37'(offs[c]) + (37'sd1 <<< (11 - FRAC_BITS))) >>> (12 - FRAC_BITS);
    end
  end

  // valid bits of the top-level stages
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic v13, v14, v15;
  // the three channel units run in lockstep, their valids agree
  logic [2:0] lg_valid;
  logic [2:0] pw_valid;

  // stage 1: input capture, dark channels forced to 1
  logic [7:0] ch1 [3];
  // stage 2: rgb to lms scaled by 255, q16
  logic [23:0] x2 [3];
  // log2 results
  logic [28:0] lg2 [3];
  // stage 3: log2 rebased and times log10(2)
  logic signed [57:0] p3 [3];
  // stage 4: log10 in q24
  logic signed [27:0] lg4 [3];
  // stage 5: lab matrix products
  logic signed [47:0] p5 [3];
  // stage 6: lab in q24
  logic signed [31:0] lab6 [3];
  // stage 7: lab times gain
  logic signed [47:0] p7 [3];
  // stage 8: affine result, saturated
  logic signed [YW-1:0] y8 [3];
  // stage 9: inverse lab matrix products
  logic signed [45:0] p9 [3];
  // stage 10: log10 of lms in q24
  logic signed [31:0] w10 [3];
  // stage 11: times log2(10), in two partial products
  logic signed [47:0] ph11 [3];
  logic signed [47:0] pl11 [3];
  // stage 12: exponent, clamped
  logic signed [30:0] e12 [3];
  // pow2 results
  logic [37:0] lms [3];
  // stage 13: lms to rgb partial products
  logic signed [39:0] ph13 [3][3];
  logic signed [39:0] pl13 [3][3];
  // stage 14: rgb in q24
  logic signed [43:0] c14 [3];
  // stage 15: scaled by 255
  logic signed [51:0] c15 [3];

  logic [7:0] in_ch [3];
  assign in_ch[0] = red_in;
  assign in_ch[1] = green_in;
  assign in_ch[2] = blue_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
      v15 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= &lg_valid;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= &pw_valid;
      v14 <= v13;
      v15 <= v14;
      out_valid <= v15;
    end
  end

  // front end up to the log units
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ch1[i] <= (in_ch[i] == 8'd0) ? 8'd1 : in_ch[i];
        x2[i]  <= 24'(lctp_pkg::TO_LMS[i][0]) * 24'(ch1[0])
                + 24'(lctp_pkg::TO_LMS[i][1]) * 24'(ch1[1])
                + 24'(lctp_pkg::TO_LMS[i][2]) * 24'(ch1[2]);
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_log
    lctp_log2 u_log2 (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v2),
      .x        (x2[c]),
      .out_valid(lg_valid[c]),
      .log2     (lg2[c])
    );
  end

  // log domain, lab matrix, affine step, inverse matrix and exponent
  logic signed [29:0] t3   [3];
  logic signed [30:0] sum5 [3];
  logic signed [31:0] xr7  [3];
  logic signed [36:0] r8   [3];
  logic signed [36:0] y8n  [3];
  logic signed [28:0] q9   [3];
  logic signed [47:0] s10  [3];
  logic signed [62:0] s12  [3];
  logic signed [34:0] e12n [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t3[i] = $signed({1'b0, lg2[i]}) - lctp_pkg::LOG_BIAS_Q24 - lctp_pkg::LOG2_255_Q24;
    end
    sum5[0] = 31'(lg4[0]) + 31'(lg4[1]) + 31'(lg4[2]);
    sum5[1] = 31'(lg4[0]) + 31'(lg4[1]) - (31'(lg4[2]) <<< 1);
    sum5[2] = 31'(lg4[0]) - 31'(lg4[1]);
    for (int i = 0; i < 3; i++) begin
      xr7[i] = (lab6[i] + (32'sd1 <<< (SH - 1))) >>> SH;
      r8[i]  = 37'((p7[i] + 48'sd2048) >>> 12);
      y8n[i] = r8[i] + off_q[i];
      if (y8n[i] < -37'(LIM)) y8n[i] = -37'(LIM);
      if (y8n[i] > 37'(LIM - 1)) y8n[i] = 37'(LIM - 1);
      q9[i] = 29'(y8[i]) <<< SH;
    end
    s10[0] = 48'(p9[0]) + 48'(p9[1]) + 48'(p9[2]);
    s10[1] = 48'(p9[0]) + 48'(p9[1]) - 48'(p9[2]);
    s10[2] = 48'(p9[0]) - (48'(p9[1]) <<< 1);
    for (int i = 0; i < 3; i++) begin
      s12[i]  = (63'(ph11[i]) <<< 15) + 63'(pl11[i]);
      e12n[i] = 35'((s12[i] + 63'sd134217728) >>> 28);
      if (e12n[i] < lctp_pkg::EXP_MIN) e12n[i] = lctp_pkg::EXP_MIN;
      if (e12n[i] > lctp_pkg::EXP_MAX) e12n[i] = lctp_pkg::EXP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3[i]   <= 58'(t3[i]) * 58'(lctp_pkg::LOG10_2_Q30);
        lg4[i]  <= 28'((p3[i] + 58'sd536870912) >>> 30);
        lab6[i] <= 32'((p5[i] + 48'sd32768) >>> 16);
        p7[i]   <= 48'(xr7[i]) * 48'(gain[i]);
        y8[i]   <= YW'(y8n[i]);
        w10[i]  <= 32'((s10[i] + 48'sd32768) >>> 16);
        ph11[i] <= 48'(w10[i]) * 48'(lctp_pkg::LOG2_10_HI);
        pl11[i] <= 48'(w10[i]) * 48'(lctp_pkg::LOG2_10_LO);
        e12[i]  <= 31'(e12n[i]);
      end
      p5[0] <= 48'(sum5[0]) * 48'(lctp_pkg::K3);
      p5[1] <= 48'(sum5[1]) * 48'(lctp_pkg::K6);
      p5[2] <= 48'(sum5[2]) * 48'(lctp_pkg::K2);
      p9[0] <= 46'(q9[0]) * 46'(lctp_pkg::K3);
      p9[1] <= 46'(q9[1]) * 46'(lctp_pkg::K6);
      p9[2] <= 46'(q9[2]) * 46'(lctp_pkg::K2);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_pow
    lctp_pow2 u_pow2 (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v12),
      .v        (e12[c]),
      .out_valid(pw_valid[c]),
      .lms      (lms[c])
    );
  end

  // back end: lms to rgb, scale by 255, saturate
  logic signed [59:0] s14  [3];
  logic signed [27:0] r16  [3];
  logic [7:0]         o16  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s14[i] = '0;
      for (int j = 0; j < 3; j++) begin
        s14[i] = s14[i] + (60'(ph13[i][j]) <<< 19) + 60'(pl13[i][j]);
      end
      r16[i] = 28'((c15[i] + 52'sd8388608) >>> 24);
      if (r16[i] < 28'sd0) o16[i] = 8'd0;
      else if (r16[i] > 28'sd255) o16[i] = 8'd255;
      else o16[i] = r16[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // lms split in two 19-bit halves
          ph13[i][j] <= 40'(lctp_pkg::TO_RGB[i][j]) * $signed({21'b0, lms[j][37:19]});
          pl13[i][j] <= 40'(lctp_pkg::TO_RGB[i][j]) * $signed({21'b0, lms[j][18:0]});
        end
        c14[i] <= 44'((s14[i] + 60'sd32768) >>> 16);
        c15[i] <= (52'(c14[i]) <<< 8) - 52'(c14[i]);
      end
      red_out   <= o16[0];
      green_out <= o16[1];
      blue_out  <= o16[2];
    end
  end

endmodule
